@@ rtl/skf_pkg.sv @@
// Shared types for the scalar Kalman filter core.
// Holds the datapath operation codes and the control and status bundles
// passed between the microcode sequencer and the datapath. No dependencies.
package skf_pkg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ADD_Q,
        OP_ADD_R,
        OP_NUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_X,
        OP_ROUND_X,
        OP_UPD_X,
        OP_MUL_P,
        OP_UPD_P,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        reload;
        logic [31:0] reload_est;
        logic [30:0] reload_cov;
    } ctrl_t;

    typedef struct packed {
        logic den_zero;
        logic div_last;
    } status_t;

endpackage

@@ rtl/skf_datapath.sv @@
// Arithmetic datapath of the scalar Kalman filter core.
// Executes one operation code per cycle from the sequencer; holds the filter
// state, the working registers and the result registers. Depends on skf_pkg.
module skf_datapath
    import skf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    output status_t            status,
    input  logic        [30:0] process_noise,
    input  logic        [30:0] measurement_noise,
    input  logic signed [31:0] measurement,
    output logic signed [31:0] estimate,
    output logic        [16:0] gain,
    output logic        [30:0] covariance,
    output logic               error
);

    localparam logic [30:0] COV_MAX = 31'h7FFF_FFFF;
    localparam logic [4:0]  DIV_STEPS = 5'd17;

    // Filter state and the sequencer-visible divide counter.
    logic signed [31:0] x_reg;
    logic        [30:0] p_reg;
    logic        [4:0]  cnt_reg;

    // Working registers.
    logic signed [31:0] meas_reg;
    logic        [30:0] pp_reg;
    logic        [31:0] den_reg;
    logic        [47:0] num_reg;
    logic        [31:0] rem_reg;
    logic        [16:0] quo_reg;
    logic signed [32:0] diff_reg;
    logic signed [50:0] prod_reg;
    logic        [34:0] rnd_reg;
    logic               neg_reg;
    logic        [47:0] prodp_reg;
    logic signed [31:0] xn_reg;
    logic        [30:0] pn_reg;
    logic        [16:0] gain_reg;
    logic               err_reg;

    // Result registers.
    logic signed [31:0] est_out_reg;
    logic        [16:0] gain_out_reg;
    logic        [30:0] cov_out_reg;
    logic               err_out_reg;

    logic        [31:0] pp_sum;
    logic        [30:0] pp_sat;
    logic        [31:0] den_sum;
    logic        [47:0] num_sum;
    logic        [32:0] trial;
    logic        [32:0] trial_sub;
    logic               trial_ge;
    logic signed [50:0] prod_x;
    logic        [50:0] mag;
    logic signed [35:0] x_ext;
    logic signed [35:0] r_ext;
    logic signed [35:0] x_sum;
    logic signed [31:0] x_sat;
    logic        [16:0] factor;
    logic        [47:0] prodp;
    logic        [47:0] p_round;

    always_comb
    begin
        pp_sum    = {1'b0, p_reg} + {1'b0, process_noise};
        pp_sat    = pp_sum[31] ? COV_MAX : pp_sum[30:0];
        den_sum   = {1'b0, pp_reg} + {1'b0, measurement_noise};
        num_sum   = {1'b0, pp_reg, 16'b0} + {17'b0, den_reg[31:1]};

        trial     = {rem_reg, quo_reg[16]};
        trial_sub = trial - {1'b0, den_reg};
        trial_ge  = !trial_sub[32];

        prod_x    = $signed({1'b0, gain_reg}) * diff_reg;

        // Round half away from zero: the magnitude gets the half added.
        if (prod_reg[50])
        begin
            mag = (~prod_reg) + 51'd32769;
        end
        else
        begin
            mag = prod_reg + 51'd32768;
        end

        x_ext = {{4{x_reg[31]}}, x_reg};
        r_ext = {1'b0, rnd_reg};
        x_sum = neg_reg ? (x_ext - r_ext) : (x_ext + r_ext);
        if (x_sum > 36'sd2147483647)
        begin
            x_sat = 32'sh7FFF_FFFF;
        end
        else if (x_sum < -36'sd2147483648)
        begin
            x_sat = 32'sh8000_0000;
        end
        else
        begin
            x_sat = x_sum[31:0];
        end

        factor  = 17'h10000 - gain_reg;
        prodp   = factor * pp_reg;
        p_round = prodp_reg + 48'd32768;
    end

    // Filter state and divide counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= 32'sd0;
            p_reg   <= 31'd65536;
            cnt_reg <= 5'd0;
        end
        else
        begin
            if (ctrl.reload)
            begin
                x_reg <= ctrl.reload_est;
                p_reg <= ctrl.reload_cov;
            end
            else if (ctrl.op == OP_FINISH)
            begin
                x_reg <= xn_reg;
                p_reg <= pn_reg;
            end
            case (ctrl.op)
                OP_DIV_INIT: cnt_reg <= DIV_STEPS;
                OP_DIV_STEP: cnt_reg <= cnt_reg - 5'd1;
                default:     cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_LOAD:
            begin
                meas_reg <= measurement;
            end
            OP_ADD_Q:
            begin
                pp_reg   <= pp_sat;
                diff_reg <= {meas_reg[31], meas_reg} - {x_reg[31], x_reg};
            end
            OP_ADD_R:
            begin
                den_reg <= den_sum;
            end
            OP_NUM:
            begin
                num_reg <= num_sum;
                // Zero denominator: no update, gain zero, flag raised.
                err_reg  <= (den_reg == 32'd0);
                gain_reg <= 17'd0;
                xn_reg   <= x_reg;
                pn_reg   <= pp_reg;
            end
            OP_DIV_INIT:
            begin
                // The quotient fits 17 bits, so the top of the numerator is
                // already below the divisor.
                rem_reg <= {1'b0, num_reg[47:17]};
                quo_reg <= num_reg[16:0];
            end
            OP_DIV_STEP:
            begin
                rem_reg <= trial_ge ? trial_sub[31:0] : trial[31:0];
                quo_reg <= {quo_reg[15:0], trial_ge};
                if (status.div_last)
                begin
                    gain_reg <= {quo_reg[15:0], trial_ge};
                end
            end
            OP_MUL_X:
            begin
                prod_reg <= prod_x;
            end
            OP_ROUND_X:
            begin
                neg_reg <= prod_reg[50];
                rnd_reg <= mag[50:16];
            end
            OP_UPD_X:
            begin
                xn_reg <= x_sat;
            end
            OP_MUL_P:
            begin
                prodp_reg <= prodp;
            end
            OP_UPD_P:
            begin
                // The scaled covariance never exceeds p', so no clamp.
                pn_reg <= p_round[46:16];
            end
            OP_FINISH:
            begin
                est_out_reg  <= xn_reg;
                gain_out_reg <= gain_reg;
                cov_out_reg  <= pn_reg;
                err_out_reg  <= err_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.den_zero = (den_reg == 32'd0);
    assign status.div_last = (cnt_reg == 5'd1);

    assign estimate   = est_out_reg;
    assign gain       = gain_out_reg;
    assign covariance = cov_out_reg;
    assign error      = err_out_reg;

endmodule

@@ rtl/scalar_kalman_filter_core.sv @@
// Scalar Kalman filter core: one measurement beat in, one result beat out.
// The result is valid once the microprogram has run its steps (the divide and
// updates are skipped when p' + r is zero), later only while the previous
// result still waits on stall. The next input is taken only after the finish
// step; the gain comes from the 17-step restoring divide.
// Reset (rst_n, asynchronous, active low) restores the register defaults and
// loads the estimate and covariance from them; no clearing pass is needed.

// Top level: configuration registers, microcode sequencer and handshakes.
// Instantiates skf_datapath; depends on skf_pkg.
module scalar_kalman_filter_core
    import skf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic        [1:0]  cfg_index,
    input  logic        [31:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] measurement,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] estimate,
    output logic        [16:0] gain,
    output logic        [30:0] covariance,
    output logic               error
);

    // Register indexes.
    localparam logic [1:0] REG_PROCESS_NOISE      = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE  = 2'd1;
    localparam logic [1:0] REG_INITIAL_ESTIMATE   = 2'd2;
    localparam logic [1:0] REG_INITIAL_COVARIANCE = 2'd3;

    // Jump conditions. When the condition holds the sequencer goes to the
    // target, otherwise to the next step.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_COUNT_LEFT,
        C_DEN_ZERO,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t        op;
        cond_t      cond;
        logic [3:0] target;
    } uword_t;

    localparam logic [3:0] PC_WAIT   = 4'd0;
    localparam logic [3:0] PC_DIV    = 4'd5;
    localparam logic [3:0] PC_FINISH = 4'd11;

    // The microprogram. Step 0 waits for a measurement beat; the divide step
    // repeats until its counter runs out; the finish step holds while the
    // previous result has not been taken.
    function automatic uword_t ucode(input logic [3:0] addr);
        uword_t w;
        case (addr)
            4'd0:    w = '{op: OP_LOAD,     cond: C_NO_INPUT,   target: PC_WAIT};
            4'd1:    w = '{op: OP_ADD_Q,    cond: C_NEVER,      target: PC_WAIT};
            4'd2:    w = '{op: OP_ADD_R,    cond: C_NEVER,      target: PC_WAIT};
            4'd3:    w = '{op: OP_NUM,      cond: C_DEN_ZERO,   target: PC_FINISH};
            4'd4:    w = '{op: OP_DIV_INIT, cond: C_NEVER,      target: PC_WAIT};
            4'd5:    w = '{op: OP_DIV_STEP, cond: C_COUNT_LEFT, target: PC_DIV};
            4'd6:    w = '{op: OP_MUL_X,    cond: C_NEVER,      target: PC_WAIT};
            4'd7:    w = '{op: OP_ROUND_X,  cond: C_NEVER,      target: PC_WAIT};
            4'd8:    w = '{op: OP_UPD_X,    cond: C_NEVER,      target: PC_WAIT};
            4'd9:    w = '{op: OP_MUL_P,    cond: C_NEVER,      target: PC_WAIT};
            4'd10:   w = '{op: OP_UPD_P,    cond: C_NEVER,      target: PC_WAIT};
            4'd11:   w = '{op: OP_FINISH,   cond: C_OUT_BUSY,   target: PC_FINISH};
            default: w = '{op: OP_NOP,      cond: C_ALWAYS,     target: PC_WAIT};
        endcase
        return w;
    endfunction

    // Configuration registers.
    logic [30:0] process_noise_reg;
    logic [30:0] measurement_noise_reg;
    logic [31:0] initial_estimate_reg;
    logic [30:0] initial_covariance_reg;

    logic [3:0]  pc_reg;
    logic [3:0]  pc_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    uword_t      word;
    logic        out_busy;
    logic        jump;
    ctrl_t       ctrl;
    status_t     status;

    assign word     = ucode(pc_reg);
    assign out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        case (word.cond)
            C_NEVER:      jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NO_INPUT:   jump = !in_valid;
            C_COUNT_LEFT: jump = !status.div_last;
            C_DEN_ZERO:   jump = status.den_zero;
            C_OUT_BUSY:   jump = out_busy;
            default:      jump = 1'b1;
        endcase
        pc_next = jump ? word.target : (pc_reg + 4'd1);

        // A waiting step does nothing until its condition clears.
        ctrl.op = word.op;
        if ((word.cond == C_NO_INPUT || word.cond == C_OUT_BUSY) && jump)
        begin
            ctrl.op = OP_NOP;
        end

        // Writing either initial register reloads the state from both.
        ctrl.reload     = cfg_write && (cfg_index == REG_INITIAL_ESTIMATE ||
                                        cfg_index == REG_INITIAL_COVARIANCE);
        ctrl.reload_est = (cfg_index == REG_INITIAL_ESTIMATE) ? cfg_data
                                                              : initial_estimate_reg;
        ctrl.reload_cov = (cfg_index == REG_INITIAL_COVARIANCE) ? cfg_data[30:0]
                                                                : initial_covariance_reg;

        // The output register is loaded on finish and cleared once taken.
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.op == OP_FINISH)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg                 <= PC_WAIT;
            out_valid_reg          <= 1'b0;
            process_noise_reg      <= 31'd655;
            measurement_noise_reg  <= 31'd65536;
            initial_estimate_reg   <= 32'd0;
            initial_covariance_reg <= 31'd65536;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PROCESS_NOISE:      process_noise_reg      <= cfg_data[30:0];
                    REG_MEASUREMENT_NOISE:  measurement_noise_reg  <= cfg_data[30:0];
                    REG_INITIAL_ESTIMATE:   initial_estimate_reg   <= cfg_data;
                    REG_INITIAL_COVARIANCE: initial_covariance_reg <= cfg_data[30:0];
                    default:                process_noise_reg      <= process_noise_reg;
                endcase
            end
        end
    end

    // Input beats are taken only in the wait step.
    assign in_stall  = (word.cond != C_NO_INPUT);
    assign out_valid = out_valid_reg;

    skf_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .status            (status),
        .process_noise     (process_noise_reg),
        .measurement_noise (measurement_noise_reg),
        .measurement       (measurement),
        .estimate          (estimate),
        .gain              (gain),
        .covariance        (covariance),
        .error             (error)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for scalar_kalman_filter_core: drives measurement beats,
// predicts each filter update in a scoreboard class and checks every result beat.
// Depends only on the RTL of the core.

module tb_top;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        REG_PROCESS_NOISE     = 2'd0,
        REG_MEASUREMENT_NOISE = 2'd1,
        REG_INITIAL_ESTIMATE  = 2'd2,
        REG_INITIAL_COVAR     = 2'd3
    } reg_index_t;

    // Named measurement patterns used by the stimulus.
    localparam logic [31:0] POS_FULL  = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_FULL  = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam longint      EST_MAX   = 64'sd2147483647;
    localparam longint      EST_MIN   = -64'sd2147483648;
    localparam longint      COV_MAX   = 64'sd2147483647;
    localparam longint      GAIN_ONE  = 64'sd65536;
    localparam longint      GAIN_HALF = 64'sd32768;

    typedef struct {
        logic signed [31:0] estimate;
        logic        [16:0] gain;
        logic        [30:0] covariance;
        logic               error;
    } filter_update_t;

    // The scoreboard keeps its own copy of the filter registers and state.
    // Every accepted measurement beat advances that copy by one filter step
    // and queues the update the core has to produce for it.
    class kalman_scoreboard;
        bit        [30:0] q_noise;
        bit        [30:0] r_noise;
        bit signed [31:0] start_est;
        bit        [30:0] start_cov;
        longint           est_now;
        bit        [30:0] cov_now;
        filter_update_t   pending[$];
        int               failures;

        function new();
            q_noise   = 31'd655;
            r_noise   = 31'd65536;
            start_est = '0;
            start_cov = 31'd65536;
            failures  = 0;
            reload();
        endfunction

        function void reload();
            est_now = longint'(start_est);
            cov_now = start_cov;
        endfunction

        function void write_register(reg_index_t idx, logic [31:0] data);
            case (idx)
                REG_PROCESS_NOISE:     q_noise = data[30:0];
                REG_MEASUREMENT_NOISE: r_noise = data[30:0];
                REG_INITIAL_ESTIMATE:
                begin
                    start_est = data;
                    reload();
                end
                REG_INITIAL_COVAR:
                begin
                    start_cov = data[30:0];
                    reload();
                end
                default: ;
            endcase
        endfunction

        // One filter step: grow the covariance, form the gain, pull the
        // estimate toward the sample and shrink the covariance.
        function void take_measurement(logic signed [31:0] meas);
            longint unsigned pp;
            longint unsigned den;
            longint unsigned k;
            longint unsigned mag;
            longint unsigned rnd;
            longint          diff;
            longint          prod;
            longint          nx;
            filter_update_t  upd;

            pp = 64'(cov_now) + 64'(q_noise);
            if (pp > COV_MAX)
                pp = COV_MAX;
            den = pp + 64'(r_noise);
            nx = est_now;
            k = 0;
            upd.error = 1'b0;
            if (den == 0)
            begin
                upd.error = 1'b1;
            end
            else
            begin
                k = ((pp << 16) + den / 2) / den;
                if (k > GAIN_ONE)
                    k = GAIN_ONE;
                diff = longint'(meas) - est_now;
                prod = longint'(k) * diff;
                // The step is rounded to nearest with halves away from zero.
                if (prod < 0)
                begin
                    mag = -prod;
                    rnd = (mag + GAIN_HALF) >> 16;
                    nx = est_now - longint'(rnd);
                end
                else
                begin
                    mag = prod;
                    rnd = (mag + GAIN_HALF) >> 16;
                    nx = est_now + longint'(rnd);
                end
                if (nx > EST_MAX)
                    nx = EST_MAX;
                if (nx < EST_MIN)
                    nx = EST_MIN;
                pp = ((GAIN_ONE - k) * pp + GAIN_HALF) >> 16;
                if (pp > COV_MAX)
                    pp = COV_MAX;
            end
            est_now = nx;
            cov_now = pp[30:0];
            upd.estimate = nx[31:0];
            upd.gain = k[16:0];
            upd.covariance = pp[30:0];
            pending.push_back(upd);
        endfunction

        function void check_result(logic signed [31:0] est, logic [16:0] k,
                                   logic [30:0] cov, logic err);
            filter_update_t want;

            if (pending.size() == 0)
            begin
                $display("%0t: result beat with no measurement outstanding", $time);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (est !== want.estimate)
            begin
                $display("%0t: estimate mismatch, expected %0d, got %0d",
                         $time, want.estimate, est);
                failures++;
            end
            if (k !== want.gain)
            begin
                $display("%0t: gain mismatch, expected %0d, got %0d", $time, want.gain, k);
                failures++;
            end
            if (cov !== want.covariance)
            begin
                $display("%0t: covariance mismatch, expected %0d, got %0d",
                         $time, want.covariance, cov);
                failures++;
            end
            if (err !== want.error)
            begin
                $display("%0t: error flag mismatch, expected %0b, got %0b",
                         $time, want.error, err);
                failures++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic        [1:0]  cfg_index;
    logic        [31:0] cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] measurement;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] estimate;
    logic        [16:0] gain;
    logic        [30:0] covariance;
    logic               error;

    kalman_scoreboard   tracker;
    logic        [31:0] feed[$];    // measurement beats waiting to be offered
    bit                 calm;       // when set, neither side idles nor stalls

    scalar_kalman_filter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .estimate    (estimate),
        .gain        (gain),
        .covariance  (covariance),
        .error       (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sender. All sampling happens right after the rising edge, so the values
    // seen are the ones the edge itself captured. A beat is taken when valid
    // is high and stall is low; only then may the payload change. About one
    // free slot in three opens a gap that can run longer than one filter step,
    // so new beats land on every phase of the core's work.
    task automatic feed_measurements();
        int gap_left;

        gap_left = 0;
        forever
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
                tracker.take_measurement(measurement);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (feed.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(99) < 37)
                begin
                    gap_left = $urandom_range(39);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    measurement <= feed.pop_front();
                end
            end
        end
    endtask

    // Receiver. Unless calm is set, stalls with a chance of about 37 in a hundred, drawn each cycle.
    task automatic collect_results();
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                tracker.check_result(estimate, gain, covariance, error);
            out_stall <= !calm && ($urandom_range(99) < 37);
        end
    endtask

    // Holds the caller until every beat has been offered and taken and every
    // expected result beat has come back.
    task automatic wait_quiet();
        while (feed.size() != 0 || in_valid || tracker.pending.size() != 0)
            @(posedge clk);
    endtask

    // Writes the registers selected by mask, in index order, once the core is
    // idle. The write enable stays high across back-to-back writes and drops
    // after the last one.
    task automatic reconfigure(input bit [3:0] mask, input logic [31:0] q_val,
                               input logic [31:0] r_val, input logic [31:0] est_val,
                               input logic [31:0] cov_val);
        logic [31:0] vals[4];
        reg_index_t  idx;

        vals = '{q_val, r_val, est_val, cov_val};
        wait_quiet();
        for (int i = 0; i < 4; i++)
        begin
            if (mask[i])
            begin
                idx = reg_index_t'(i);
                cfg_write <= 1'b1;
                cfg_index <= idx;
                cfg_data  <= vals[i];
                @(posedge clk);
                tracker.write_register(idx, vals[i]);
            end
        end
        cfg_write <= 1'b0;
    endtask

    // Noise and covariance values: zero, the full range (with and without the
    // ignored top bit), and small to large magnitudes.
    function automatic logic [31:0] pick_variance();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return POS_FULL;
            3, 4:    return $urandom_range(255);
            5, 6:    return $urandom_range(32'h0010_0000);
            7, 8:    return $urandom_range(32'h0100_0000, 32'h0000_1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_level();
        case ($urandom_range(5))
            0:       return POS_FULL;
            1:       return NEG_FULL;
            2, 3:    return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    // A sample near the tracked level with noise of the given size, clamped
    // to the signed 32-bit range.
    function automatic logic [31:0] noisy_sample(logic [31:0] level, int spread);
        longint v;

        v = longint'($signed(level)) + longint'($urandom_range(2 << spread))
            - (longint'(1) << spread);
        if (v > EST_MAX)
            v = EST_MAX;
        if (v < EST_MIN)
            v = EST_MIN;
        return v[31:0];
    endfunction

    initial
    begin
        logic [31:0] level;
        int          spread;
        int          pick;
        bit   [3:0]  mask;

        tracker     = new();
        calm        = 1'b0;
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= REG_PROCESS_NOISE;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        measurement <= '0;
        out_stall   <= 1'b0;

        fork
            feed_measurements();
            collect_results();
        join_none

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults with the extremes and alternating bit patterns.
        feed = '{32'h0, POS_FULL, NEG_FULL, ALL_ONES, 32'h1, 32'h5555_5555, 32'hAAAA_AAAA};

        // All noise and covariance zero: the gain denominator is zero, so the
        // core flags an error and leaves the estimate where it is.
        reconfigure(4'hF, 32'h0, 32'h0, NEG_FULL, 32'h0);
        feed = '{POS_FULL, 32'h0, NEG_FULL};

        // Top bits beyond a register's width are ignored; the covariance
        // saturates and with no measurement noise the gain is exactly one.
        reconfigure(4'hF, ALL_ONES, 32'h0, POS_FULL, ALL_ONES);
        feed = '{NEG_FULL, 32'h1234_5678, POS_FULL};

        // Both noises at full scale: gain near one half, full-swing inputs.
        reconfigure(4'hF, POS_FULL, ALL_ONES, 32'h0, POS_FULL);
        feed = '{POS_FULL, NEG_FULL, 32'h0};

        // Tiny values: a gain of one half on the first sample, rounding halves away from zero.
        reconfigure(4'hF, 32'h1, 32'h1, ALL_ONES, 32'h0);
        feed = '{32'h0, 32'hFFFF_FFFE, 32'h0};

        // Huge measurement noise: the gain rounds to zero.
        reconfigure(4'hF, 32'h0, POS_FULL, 32'h0, 32'h1);
        feed = '{POS_FULL, NEG_FULL};

        // Random phases. Most samples follow a level with random noise so the
        // filter converges; the rest are full-range noise and extremes.
        for (int ph = 0; ph < 12; ph++)
        begin
            mask = (ph == 0) ? 4'hF : 4'($urandom_range(15));
            reconfigure(mask, pick_variance(), pick_variance(), pick_level(),
                        pick_variance());
            calm = (ph == 5);
            level = pick_level();
            spread = $urandom_range(24, 4);
            for (int n = 0; n < 42; n++)
            begin
                // One sender pause in the middle of a phase until the core
                // has returned every pending result.
                if (ph == 2 && n == 21)
                    wait_quiet();
                if ($urandom_range(99) < 5)
                    level = pick_level();
                pick = $urandom_range(99);
                if (pick < 60)
                    feed.push_back(noisy_sample(level, spread));
                else if (pick < 85)
                    feed.push_back($urandom);
                else
                    case ($urandom_range(3))
                        0:       feed.push_back(POS_FULL);
                        1:       feed.push_back(NEG_FULL);
                        2:       feed.push_back(32'h0);
                        default: feed.push_back(ALL_ONES);
                    endcase
            end
        end

        wait_quiet();
        calm = 1'b0;
        // Any stray result beat in this window is flagged by the receiver.
        repeat (60) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending.size() == 0)
            $display("scalar_kalman_filter_core test passed");
        else
            $display("scalar_kalman_filter_core test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #6_000_000;
        $display("scalar_kalman_filter_core test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/skf_pkg.sv
rtl/skf_datapath.sv
rtl/scalar_kalman_filter_core.sv
sim/tb_top.sv
